// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define ARX_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/arxsc_pkg.sv -----
// Shared types, constants and helper functions of the add-rotate-xor cipher.
package arxsc_pkg;

  localparam int WORD_W       = 32;
  localparam int NUM_WORDS    = 8;
  localparam int KEY_REG_W    = 64;
  localparam int NUM_CFG_REGS = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int BYTES        = 4;
  localparam int COUNT_W      = 3;
  localparam int SETUP_ROUNDS = 64;
  localparam int ROUND_W      = $clog2(SETUP_ROUNDS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_01   = 3'd0,
    CFG_KEY_23   = 3'd1,
    CFG_KEY_45   = 3'd2,
    CFG_KEY_67   = 3'd3,
    CFG_NONCE_01 = 3'd4,
    CFG_NONCE_23 = 3'd5
  } cfg_idx_t;

  // Item kinds.
  typedef enum logic {
    OP_SETUP = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  // One classified item as it travels from the front end to the engine.
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] data;
    logic [BYTES-1:0]  byte_en;
  } item_t;

  // Engine states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_ROUND,
    ST_FINAL,
    ST_FOLD,
    ST_DONE
  } state_t;

  // Rotate a word left by two bits.
  function automatic logic [WORD_W-1:0] rotl2(input logic [WORD_W-1:0] v);
    return {v[WORD_W-3:0], v[WORD_W-1:WORD_W-2]};
  endfunction

  // Byte enables for a byte count; counts of four and above enable all bytes.
  function automatic logic [BYTES-1:0] count_to_byte_en(input logic [COUNT_W-1:0] n);
    logic [BYTES-1:0] en;
    en = '0;
    for (int b = 0; b < BYTES; b++) begin
      en[b] = (n > COUNT_W'(b));
    end
    return en;
  endfunction

  // Widen byte enables into a bit mask.
  function automatic logic [WORD_W-1:0] byte_en_to_mask(input logic [BYTES-1:0] en);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < BYTES; b++) begin
      m[b*8 +: 8] = {8{en[b]}};
    end
    return m;
  endfunction

endpackage

// ----- rtl/arxsc_front.sv -----
// Input front end: accepts items, classifies them and queues them for the engine.
module arxsc_front
  import arxsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  q_valid,
  output item_t                 q_item,
  input  logic                  q_pop
);

  item_t             queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;
  item_t             new_item;

  // Classify the incoming item and precompute its byte enables.
  always_comb begin
    new_item.op      = op_t'(in_tuser);
    new_item.data    = in_tdata[WORD_W-1:0];
    new_item.byte_en = count_to_byte_en(in_tdata[WORD_W +: COUNT_W]);
  end

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = queue_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- rtl/arxsc_core.sv -----
// Cipher engine: key setup, word-serial rounds, keystream fold and result register.
module arxsc_core
  import arxsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [KEY_REG_W-1:0]   cfg_data,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  state_t             state_r, state_nxt;
  logic [KEY_REG_W-1:0] cfg_r [NUM_CFG_REGS];
  logic [WORD_W-1:0]  words_r [NUM_WORDS];
  logic [WORD_W-1:0]  sum_r;
  logic [WORD_W-1:0]  ctr_r;
  logic [WORD_W-1:0]  k_r;
  logic [2:0]         step_r;
  logic [ROUND_W-1:0] rounds_r;
  item_t              item_r;
  logic               keyed_r;
  logic               out_valid_r;
  logic [WORD_W-1:0]  out_data_r;
  logic [WORD_W-1:0]  out_ks_r;
  logic               out_nk_r;

  logic               pop;
  logic               out_load;
  logic               step_last;
  logic               round_last;
  logic               fold_last;
  logic [WORD_W-1:0]  new_word;
  logic [WORD_W-1:0]  fold_a;
  logic [WORD_W-1:0]  fold_b;

  // One word update of a round on the two words at the head of the rotating array.
  assign new_word = rotl2((words_r[0] + words_r[1] + sum_r) ^ words_r[0]);

  // Keystream fold operands for the current fold step.
  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        fold_a = words_r[0];
        fold_b = words_r[6];
      end
      2'd1: begin
        fold_a = words_r[1];
        fold_b = words_r[5];
      end
      2'd2: begin
        fold_a = words_r[2];
        fold_b = words_r[4];
      end
      default: begin
        fold_a = words_r[3];
        fold_b = words_r[7];
      end
    endcase
  end

  assign step_last  = (step_r == 3'd7);
  assign round_last = step_last && (rounds_r == ROUND_W'(1));
  assign fold_last  = (step_r[1:0] == 2'd3);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_SETUP) begin
            state_nxt = ST_SEED;
          end else if (keyed_r) begin
            state_nxt = ST_ROUND;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SEED: begin
        if (step_last) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_last) begin
          state_nxt = (item_r.op == OP_SETUP) ? ST_FINAL : ST_FOLD;
        end
      end
      ST_FINAL: begin
        if (step_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FOLD: begin
        if (fold_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: pop      = q_valid;
      ST_DONE: out_load = !out_valid_r || out_tready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign q_pop = pop;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FINAL && step_last) begin
        keyed_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_01:   cfg_r[0] <= cfg_data;
        CFG_KEY_23:   cfg_r[1] <= cfg_data;
        CFG_KEY_45:   cfg_r[2] <= cfg_data;
        CFG_KEY_67:   cfg_r[3] <= cfg_data;
        CFG_NONCE_01: cfg_r[4] <= cfg_data;
        CFG_NONCE_23: cfg_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mixing state, sum, counter and sequencing counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_r[i] <= '0;
      end
      sum_r    <= '0;
      ctr_r    <= '0;
      k_r      <= '0;
      step_r   <= '0;
      rounds_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          k_r    <= '0;
          if (pop) begin
            if (q_item.op == OP_SETUP) begin
              // Load key words and fold in the nonce.
              for (int i = 0; i < NUM_WORDS / 4; i++) begin
                words_r[2*i]     <= cfg_r[i][KEY_REG_W-1:WORD_W];
                words_r[2*i + 1] <= cfg_r[i][WORD_W-1:0];
              end
              words_r[4] <= cfg_r[2][KEY_REG_W-1:WORD_W] ^ cfg_r[4][KEY_REG_W-1:WORD_W];
              words_r[5] <= cfg_r[2][WORD_W-1:0] ^ cfg_r[4][WORD_W-1:0];
              words_r[6] <= cfg_r[3][KEY_REG_W-1:WORD_W] ^ cfg_r[5][KEY_REG_W-1:WORD_W];
              words_r[7] <= cfg_r[3][WORD_W-1:0] ^ cfg_r[5][WORD_W-1:0];
              sum_r      <= '0;
              rounds_r   <= ROUND_W'(SETUP_ROUNDS);
            end else begin
              rounds_r <= ROUND_W'(1);
            end
          end
        end
        ST_SEED: begin
          // Sum the words one per cycle; the counter starts from the same sum.
          sum_r  <= sum_r + words_r[0];
          ctr_r  <= sum_r + words_r[0];
          step_r <= step_r + 3'd1;
          for (int i = 0; i < NUM_WORDS - 1; i++) begin
            words_r[i] <= words_r[i + 1];
          end
          words_r[NUM_WORDS - 1] <= words_r[0];
        end
        ST_ROUND: begin
          sum_r  <= sum_r + new_word + ctr_r;
          ctr_r  <= ctr_r + 32'd1;
          step_r <= step_r + 3'd1;
          for (int i = 0; i < NUM_WORDS - 1; i++) begin
            words_r[i] <= words_r[i + 1];
          end
          words_r[NUM_WORDS - 1] <= new_word;
          if (step_last) begin
            rounds_r <= rounds_r - ROUND_W'(1);
          end
        end
        ST_FINAL: begin
          sum_r  <= sum_r + words_r[0];
          step_r <= step_r + 3'd1;
          for (int i = 0; i < NUM_WORDS - 1; i++) begin
            words_r[i] <= words_r[i + 1];
          end
          words_r[NUM_WORDS - 1] <= words_r[0];
        end
        ST_FOLD: begin
          k_r    <= (k_r ^ fold_a) + fold_b;
          step_r <= step_r + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // Current item and result payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
    if (out_load) begin
      out_data_r <= (item_r.op == OP_SETUP) ? '0
                    : ((item_r.data ^ k_r) & byte_en_to_mask(item_r.byte_en));
      out_ks_r   <= k_r;
      out_nk_r   <= (item_r.op == OP_DATA) && !keyed_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ks_r, out_data_r};
  assign out_tuser  = out_nk_r;

endmodule

// ----- rtl/eight_word_add_rotate_xor_stream_cipher_unit.sv -----
// Top level of the eight-word add-rotate-xor stream cipher unit.
//
//   channel  ports       contents
//   -------  ----------  -------------------------------------------------
//   input    in_*        tuser: func; tdata: data_in, byte_count
//   result   out_*       tuser: not_keyed; tdata: data_out, keystream_word
//   config   cfg_*       write enable, register index, 64-bit write data
//
// A data item after key setup is taken off the queue, passes eight word updates
// of one round (one word per cycle) and four fold steps and loads the result
// register. A key setup seeds the sum and counter and runs 64 rounds of eight
// word updates. Data before any key setup skips the rounds and the fold. Reset
// is synchronous and clears the state, keys and queue. A two-entry queue
// takes items until full while the engine works or a result waits to be taken.
module eight_word_add_rotate_xor_stream_cipher_unit
  import arxsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_in[31:0], byte_count[34:32], zero pad
  input  logic                   in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data_out[31:0], keystream_word[63:32]
  output logic                   out_tuser,  // not_keyed
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [KEY_REG_W-1:0]   cfg_data
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // Front end: accept and classify.
  arxsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Back end: cipher engine and result register.
  arxsc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/arxsc_checker.sv -----
// Port-level checker for the cipher unit and its bind to the top level.
`include "assert_macros.svh"

module arxsc_checker
  import arxsc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A stalled result keeps its payload.
  `ARX_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A pass-through result before keying carries no keystream.
  `ARX_ASSERT_SAME(a_nk_no_ks, clk, !rst_n, out_tvalid && out_tuser, out_tdata[OUT_TDATA_W-1:WORD_W] == '0, "unkeyed result carries keystream")

  // Reset empties the result register and opens the input.
  `ARX_ASSERT_NEXT_ALWAYS(a_reset_state, clk, !rst_n, !out_tvalid && in_tready, "bad state after reset")

  // No result can appear in the cycle right after reset ends.
  `ARX_ASSERT_NEXT(a_no_early_out, clk, !rst_n, $rose(rst_n), !out_tvalid, "result right after reset")

endmodule

bind eight_word_add_rotate_xor_stream_cipher_unit arxsc_checker u_arxsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
